// ===== hdl/stl_pkg.sv =====
// Shared types and constants for the sound-triggered lamp controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package stl_pkg;

  localparam int MagW      = 14;
  localparam int MagMax    = 8192;
  localparam int WindowDef = 50;
  localparam int TimeW     = 16;

  typedef logic [MagW-1:0]  mag_t;
  typedef logic [TimeW-1:0] ticks_t;

  // Item kinds
  localparam logic [1:0] KindTick   = 2'd0;
  localparam logic [1:0] KindSample = 2'd1;
  localparam logic [1:0] KindButton = 2'd2;

  localparam mag_t   Centre       = mag_t'(MagMax);
  localparam ticks_t TickMax      = '1;
  localparam ticks_t TimeoutReset = ticks_t'(50);

  // Fixed taps of the magnitude window
  typedef struct packed {
    mag_t oldest;    // leaves the whole window on the next shift
    mag_t boundary;  // leaves the recent part on the next shift
  } taps_t;

endpackage

// ===== hdl/stl_cell.sv =====
// One cell of the magnitude window: a 14-bit register that takes its
// neighbour's value on every shift. Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  stl_pkg::mag_t mag_i,
  output stl_pkg::mag_t mag_o
);
  import stl_pkg::*;

  mag_t mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
    end else if (shift_i) begin
      mag_q <= mag_i;
    end
  end

  assign mag_o = mag_q;

endmodule

// ===== hdl/stl_window.sv =====
// Window of recent magnitudes as a chain of stl_cell, newest at the top.
// Exposes the two fixed taps that the running sums need. Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_window #(
  parameter int Window = stl_pkg::WindowDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  stl_pkg::mag_t  mag_i,
  output stl_pkg::taps_t taps_o
);
  import stl_pkg::*;

  localparam int RecentStart = Window * 4 / 5;

  mag_t chain [Window+1];

  assign chain[Window] = mag_i;

  for (genvar k = 0; k < Window; k++) begin : g_cell
    stl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .mag_i  (chain[k+1]),
      .mag_o  (chain[k])
    );
  end

  assign taps_o.oldest   = chain[0];
  assign taps_o.boundary = chain[RecentStart];

endmodule

// ===== hdl/sound_triggered_lamp_control.sv =====
// Top level of the sound-triggered lamp controller.
// Depends on stl_pkg, stl_window and stl_cell.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one item per transfer:
//   kind_i 0 is a timer tick, 1 a microphone sample with light_ok_i, 2 a
//   button press; kind 3 changes nothing. Every item gives exactly one
//   result on the output channel (out_valid_o / out_ready_i): lamp_on_o is
//   the lamp state after the item, sound_detected_o flags a loud sample. The
//   configuration channel (cfg_valid_i / cfg_ready_o) writes timeout_ticks;
//   it is always ready. Write it only while idle; the block does not check.
// Timing
//   Two stages: the window chain and running sums take the item in the
//   cycle of its transfer, the lamp and time logic then resolves it into
//   the output register when stage B can advance. Throughput is one item
//   per cycle while out_ready_i does not stall the output.
// Reset
//   All window cells clear at once (flip-flops, no clearing pass), sums and
//   elapsed time go to zero, the lamp is off and the timeout is 50 ticks.
// Stalls
//   A stalled result holds in the output register; one more item may wait
//   in the first stage, after which in_ready_o drops until a transfer out.
module sound_triggered_lamp_control #(
  parameter int Window = stl_pkg::WindowDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  stl_pkg::ticks_t  cfg_timeout_ticks_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic [13:0]      sample_value_i,
  input  logic             light_ok_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             lamp_on_o,
  output logic             sound_detected_o
);
  import stl_pkg::*;

  localparam int RecentN = Window - Window * 4 / 5;
  localparam int TotalW  = $clog2(Window * MagMax + 1);
  localparam int RecentW = $clog2(RecentN * MagMax + 1);
  localparam int CmpW    = TotalW + 6;

  // Configuration: always ready
  ticks_t timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_timeout_ticks_i;
    end
  end

  // Handshake between stages
  logic a_valid_q, b_valid_q;
  logic b_adv, a_move, in_xfer;

  assign b_adv      = !b_valid_q || out_ready_i;
  assign a_move     = a_valid_q && b_adv;
  assign in_ready_o = !a_valid_q || b_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Stage A: centre the sample, shift the window, update the sums
  logic   is_sample;
  mag_t   mag;
  taps_t  taps;
  logic [TotalW-1:0]  total_q, total_d;
  logic [RecentW-1:0] recent_q, recent_d;

  assign is_sample = in_xfer && (kind_i == KindSample);
  assign mag = sample_value_i[MagW-1] ? {1'b0, sample_value_i[MagW-2:0]}
                                      : mag_t'(Centre - sample_value_i);

  stl_window #(
    .Window(Window)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(is_sample),
    .mag_i  (mag),
    .taps_o (taps)
  );

  assign total_d  = total_q - TotalW'(taps.oldest) + TotalW'(mag);
  assign recent_d = recent_q - RecentW'(taps.boundary) + RecentW'(mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      recent_q <= '0;
    end else if (is_sample) begin
      total_q  <= total_d;
      recent_q <= recent_d;
    end
  end

  logic [1:0] a_kind_q;
  logic       a_light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_kind_q  <= kind_i;
      a_light_q <= light_ok_i;
    end
  end

  // Stage B: loudness test on the sums left by the item in stage A.
  // 40*recent > 11*total, both built from shifts and adds.
  logic [CmpW-1:0] lhs, rhs;
  logic            sound;

  assign lhs   = (CmpW'(recent_q) << 5) + (CmpW'(recent_q) << 3);
  assign rhs   = (CmpW'(total_q) << 3) + (CmpW'(total_q) << 1) + CmpW'(total_q);
  assign sound = lhs > rhs;

  ticks_t elapsed_q, elapsed_d;
  logic   lamp_q, lamp_d, sound_q, sound_d;

  always_comb begin
    elapsed_d = elapsed_q;
    lamp_d    = lamp_q;
    sound_d   = 1'b0;
    unique case (a_kind_q)
      KindTick: begin
        if (elapsed_q != TickMax) elapsed_d = elapsed_q + ticks_t'(1);
      end
      KindSample: begin
        sound_d = sound;
        // timeout first, then a qualified loud sample may relight
        if (elapsed_q >= timeout_q) lamp_d = 1'b0;
        if (sound && a_light_q) begin
          lamp_d    = 1'b1;
          elapsed_d = '0;
        end
      end
      KindButton: begin
        lamp_d = !lamp_q;
        if (!lamp_q) elapsed_d = '0;
      end
      default: begin
        // unused kind: hold all state
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      elapsed_q <= '0;
      lamp_q    <= 1'b0;
    end else begin
      if (b_adv) b_valid_q <= a_valid_q;
      if (a_move) begin
        elapsed_q <= elapsed_d;
        lamp_q    <= lamp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) sound_q <= sound_d;
  end

  assign out_valid_o      = b_valid_q;
  assign lamp_on_o        = lamp_q;
  assign sound_detected_o = sound_q;

  // Assertions
  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_adv) |=> a_valid_q)
    else $error("stage A dropped an item while blocked");

  a_sums_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= TotalW'(recent_q))
    else $error("recent sum exceeds total sum");

  a_sound_only_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_move && a_kind_q != KindSample) |=> !sound_detected_o)
    else $error("sound flagged on a non-sample item");

  a_relight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_move && a_kind_q == KindSample && sound && a_light_q)
      |=> (lamp_on_o && elapsed_q == '0))
    else $error("loud lit sample did not turn the lamp on");

endmodule
